### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication that is also checked around reset
`define ASSERT_RAW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/alvc_pkg.sv
// shared types and constants of the light and temperature vent controller
package alvc_pkg;

  localparam int DATA_W  = 12;
  localparam int DUTY_W  = 10;
  localparam int SERVO_W = 9;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // register indexes
  localparam logic [2:0] REG_OPEN    = 3'd0;
  localparam logic [2:0] REG_CLOSE   = 3'd1;
  localparam logic [2:0] REG_COVERED = 3'd2;
  localparam logic [2:0] REG_SHADED  = 3'd3;
  localparam logic [2:0] REG_BRIGHT  = 3'd4;
  localparam logic [2:0] REG_DIM     = 3'd5;
  localparam logic [2:0] REG_OFF     = 3'd6;

  // register reset values
  localparam logic [DATA_W-1:0] OPEN_RST    = 12'd1352;
  localparam logic [DATA_W-1:0] CLOSE_RST   = 12'd1269;
  localparam logic [DATA_W-1:0] COVERED_RST = 12'd40;
  localparam logic [DATA_W-1:0] SHADED_RST  = 12'd120;
  localparam logic [DUTY_W-1:0] BRIGHT_RST  = 10'd999;
  localparam logic [DUTY_W-1:0] DIM_RST     = 10'd200;
  localparam logic [DUTY_W-1:0] OFF_RST     = 10'd5;

  // servo positions
  localparam int SERVO_SHUT = 60;
  localparam int SERVO_OPEN = 260;
  localparam int SERVO_STEP = 5;
  localparam int SERVO_MAX  = 511;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [DATA_W-1:0] open_level;
    logic [DATA_W-1:0] close_level;
    logic [DATA_W-1:0] covered_level;
    logic [DATA_W-1:0] shaded_level;
    logic [DUTY_W-1:0] bright_duty;
    logic [DUTY_W-1:0] dim_duty;
    logic [DUTY_W-1:0] off_duty;
  } alvc_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] led;
    logic              vent;
    logic              switched;
  } alvc_cmd_t;

endpackage

### hdl/alvc_regs.sv
// configuration register file behind the apb port
module alvc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alvc_pkg::APB_AW-1:0] paddr,
  input  logic [alvc_pkg::APB_DW-1:0] pwdata,
  output logic [alvc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output alvc_pkg::alvc_cfg_t        cfg
);
  import alvc_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_level    <= OPEN_RST;
      cfg.close_level   <= CLOSE_RST;
      cfg.covered_level <= COVERED_RST;
      cfg.shaded_level  <= SHADED_RST;
      cfg.bright_duty   <= BRIGHT_RST;
      cfg.dim_duty      <= DIM_RST;
      cfg.off_duty      <= OFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OPEN:    cfg.open_level    <= pwdata[DATA_W-1:0];
        REG_CLOSE:   cfg.close_level   <= pwdata[DATA_W-1:0];
        REG_COVERED: cfg.covered_level <= pwdata[DATA_W-1:0];
        REG_SHADED:  cfg.shaded_level  <= pwdata[DATA_W-1:0];
        REG_BRIGHT:  cfg.bright_duty   <= pwdata[DUTY_W-1:0];
        REG_DIM:     cfg.dim_duty      <= pwdata[DUTY_W-1:0];
        REG_OFF:     cfg.off_duty      <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_OPEN:    prdata = APB_DW'(cfg.open_level);
      REG_CLOSE:   prdata = APB_DW'(cfg.close_level);
      REG_COVERED: prdata = APB_DW'(cfg.covered_level);
      REG_SHADED:  prdata = APB_DW'(cfg.shaded_level);
      REG_BRIGHT:  prdata = APB_DW'(cfg.bright_duty);
      REG_DIM:     prdata = APB_DW'(cfg.dim_duty);
      REG_OFF:     prdata = APB_DW'(cfg.off_duty);
      default:     prdata = '0;
    endcase
  end

endmodule

### hdl/alvc_front.sv
// front end: sample accumulation, window decision and command generation
module alvc_front #(
  parameter int WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  alvc_pkg::alvc_cfg_t          cfg,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [alvc_pkg::DATA_W-1:0]  temp_sample,
  input  logic [alvc_pkg::DATA_W-1:0]  light_sample,
  input  logic                         q_full,
  output logic                         push,
  output alvc_pkg::alvc_cmd_t          push_cmd
);
  import alvc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int TH_W  = SUM_W + 1;
  localparam logic [TH_W-1:0]  WIN_K    = TH_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  temp_sum;
  logic [SUM_W-1:0]  light_sum;
  logic              vent_is_open;
  logic [DUTY_W-1:0] led_level;

  logic              accept;
  logic              win_end;
  logic [SUM_W-1:0]  temp_sum_next;
  logic [SUM_W-1:0]  light_sum_next;
  logic [TH_W-1:0]   tsum_x;
  logic [TH_W-1:0]   lsum_x;
  logic [TH_W-1:0]   th_open, th_close_hi, th_cov, th_cov_hi, th_sh, th_sh_hi;
  logic              lt_cov, gt_cov, lt_sh, gt_sh, ge_open, le_close;
  logic [DUTY_W-1:0] led_next;
  logic              vent_next;

  assign s_ready = !q_full;
  assign accept  = s_valid && s_ready;
  assign win_end = (sample_count == CNT_LAST);

  assign temp_sum_next  = temp_sum + SUM_W'(temp_sample);
  assign light_sum_next = light_sum + SUM_W'(light_sample);
  assign tsum_x = TH_W'(temp_sum_next);
  assign lsum_x = TH_W'(light_sum_next);

  // levels scaled by the window so the sums compare without a divide
  assign th_open     = TH_W'(cfg.open_level) * WIN_K;
  assign th_close_hi = (TH_W'(cfg.close_level) + 1'b1) * WIN_K;
  assign th_cov      = TH_W'(cfg.covered_level) * WIN_K;
  assign th_cov_hi   = (TH_W'(cfg.covered_level) + 1'b1) * WIN_K;
  assign th_sh       = TH_W'(cfg.shaded_level) * WIN_K;
  assign th_sh_hi    = (TH_W'(cfg.shaded_level) + 1'b1) * WIN_K;

  // floor(sum / window) against each level
  assign lt_cov   = lsum_x < th_cov;
  assign gt_cov   = lsum_x >= th_cov_hi;
  assign lt_sh    = lsum_x < th_sh;
  assign gt_sh    = lsum_x >= th_sh_hi;
  assign ge_open  = tsum_x >= th_open;
  assign le_close = tsum_x < th_close_hi;

  // led and vent decision at window end
  always_comb begin
    led_next = led_level;
    if (lt_cov) begin
      led_next = cfg.bright_duty;
    end else if (gt_cov && lt_sh) begin
      led_next = cfg.dim_duty;
    end else if (gt_sh) begin
      led_next = cfg.off_duty;
    end
    if (!vent_is_open) begin
      vent_next = ge_open && gt_cov;
    end else begin
      vent_next = !(le_close || lt_cov);
    end
  end

  // command for the back end
  assign push              = accept;
  assign push_cmd.led      = win_end ? led_next : led_level;
  assign push_cmd.vent     = win_end ? vent_next : vent_is_open;
  assign push_cmd.switched = win_end && (vent_next != vent_is_open);

  // accumulator and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      temp_sum     <= '0;
      light_sum    <= '0;
      vent_is_open <= 1'b0;
      led_level    <= '0;
    end else if (accept) begin
      if (win_end) begin
        sample_count <= '0;
        temp_sum     <= '0;
        light_sum    <= '0;
        vent_is_open <= vent_next;
        led_level    <= led_next;
      end else begin
        sample_count <= sample_count + 1'b1;
        temp_sum     <= temp_sum_next;
        light_sum    <= light_sum_next;
      end
    end
  end

endmodule

### hdl/alvc_queue.sv
// short command queue between the front and back ends
module alvc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  alvc_pkg::alvc_cmd_t push_cmd,
  input  logic                pop,
  output alvc_pkg::alvc_cmd_t head,
  output logic                empty,
  output logic                full
);
  import alvc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  alvc_cmd_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/alvc_back.sv
// back end: expands commands into results, ramps the servo on a switch
module alvc_back #(
  parameter int RAMP_STEPS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  alvc_pkg::alvc_cmd_t head,
  input  logic                empty,
  output logic                pop,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [23:0]         m_data,
  output logic                m_last
);
  import alvc_pkg::*;

  localparam int STEP_W = $clog2(RAMP_STEPS + 1);
  localparam int SV_W   = (((STEP_W + 3) > SERVO_W) ? (STEP_W + 3) : SERVO_W) + 2;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RAMP_STEPS);

  logic [STEP_W-1:0]       step;
  logic                    load;
  logic                    emit;
  logic                    final_step;
  logic signed [SV_W-1:0]  step_x5;
  logic signed [SV_W-1:0]  ramp_v;
  logic [SERVO_W-1:0]      ramp_servo;
  logic [SERVO_W-1:0]      rest_servo;
  logic [SERVO_W-1:0]      servo;

  assign load       = !m_valid || m_ready;
  assign emit       = load && !empty;
  assign final_step = !head.switched || (step == STEP_LAST);
  assign pop        = emit && final_step;

  // ramp position with saturation
  assign step_x5 = $signed(SV_W'(step)) * $signed(SV_W'(SERVO_STEP));
  assign ramp_v  = head.vent ? ($signed(SV_W'(SERVO_SHUT)) + step_x5)
                             : ($signed(SV_W'(SERVO_OPEN)) - step_x5);

  always_comb begin
    if (ramp_v < 0) begin
      ramp_servo = '0;
    end else if (ramp_v > $signed(SV_W'(SERVO_MAX))) begin
      ramp_servo = SERVO_W'(SERVO_MAX);
    end else begin
      ramp_servo = ramp_v[SERVO_W-1:0];
    end
  end

  assign rest_servo = head.vent ? SERVO_W'(SERVO_OPEN) : SERVO_W'(SERVO_SHUT);
  assign servo      = head.switched ? ramp_servo : rest_servo;

  // output valid and ramp step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      step    <= STEP_W'(1);
    end else if (load) begin
      m_valid <= !empty;
      if (emit) begin
        step <= pop ? STEP_W'(1) : step + 1'b1;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_data <= {4'b0000, head.vent, servo, head.led};
      m_last <= final_step;
    end
  end

endmodule

### hdl/averaged_light_temp_vent_controller.sv
// top level of the averaged light and temperature vent controller
// Usage:
// - s_* channel takes one pair of sensor samples a request, one per cycle
//   when s_tready is high; s_tready drops only while the command queue is full.
// - every WINDOW samples the averaged light sets the led duty and the
//   averaged temperature and light switch the vent flag with hysteresis.
// - m_* channel gives one result per sample; on a vent switch that sample
//   gives a servo ramp of RAMP_STEPS results instead, m_tlast on the final one.
// - from sample accept, the first result passes the command queue and then the output register.
// - results leave at one per cycle from the output register while m_tready is high; a ramp
//   holds the back end for its RAMP_STEPS results while the front keeps taking samples
//   until the QUEUE_DEPTH-entry command queue fills.
// - when m_tready is low the output register holds its result and the queue
//   absorbs further commands; the front stalls only once it is full.
// - apb port: registers at byte address 4*index, written in the access cycle,
//   pready always high; write only while the block is idle.
// - reset (rst, synchronous) restores register defaults, clears sums, count,
//   led level and vent flag, and empties the queue; no clearing pass.
module averaged_light_temp_vent_controller #(
  parameter int WINDOW     = 64,
  parameter int RAMP_STEPS = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alvc_pkg::APB_AW-1:0] paddr,
  input  logic [alvc_pkg::APB_DW-1:0] pwdata,
  output logic [alvc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // temp_sample[11:0], light_sample[23:12]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // led_duty[9:0], servo_duty[18:10],
                                                 // vent_open[19], zero[23:20]
  output logic                        m_tlast
);
  import alvc_pkg::*;

  alvc_cfg_t cfg;
  alvc_cmd_t push_cmd;
  alvc_cmd_t head;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  // configuration registers
  alvc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sample accumulation and window decision
  alvc_front #(.WINDOW(WINDOW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .temp_sample  (s_tdata[11:0]),
    .light_sample (s_tdata[23:12]),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // command queue
  alvc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // result generation
  alvc_back #(.RAMP_STEPS(RAMP_STEPS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (q_empty),
    .pop     (pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (m_tdata),
    .m_last  (m_tlast)
  );

endmodule

### hdl/alvc_checker.sv
// port-level checks on the result stream, bound to the top level
`include "assert_macros.svh"

module alvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result stays offered
  `ASSERT_NXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")

  // a stalled result keeps its payload
  `ASSERT_NXT(a_hold_data, clk, rst, m_tvalid && !m_tready,
              $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  // within one run led duty and vent flag do not change
  `ASSERT_IMP(a_run_state, clk, rst,
              $past(m_tvalid && m_tready && !m_tlast) && m_tvalid,
              (m_tdata[9:0] == $past(m_tdata[9:0])) && (m_tdata[19] == $past(m_tdata[19])),
              "led or vent changed inside a run")

  // nothing is offered in the first cycle out of reset
  `ASSERT_RAW(a_reset_idle, clk, $past(rst) && !rst, !m_tvalid, "result offered after reset")

endmodule

bind averaged_light_temp_vent_controller alvc_checker u_alvc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
